// ===== hw/rtl/rpn_stack_evaluator_assert.svh =====
// assertion macros for the rpn stack evaluator
// used by the top level; expects clk and rst in scope
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define RPN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rpn_pkg.sv =====
// shared types and constants for the rpn stack evaluator
// no dependencies
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = 7;
  localparam int CNT_W       = $clog2(DATA_W);

  localparam logic [2:0] FN_PUSH = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_FEW      = 2'd1;
  localparam logic [1:0] ERR_DIVZERO  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    K_PUSH,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] value;
    logic              start;
  } token_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_WB,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpn_front.sv =====
// front end: accepts requests, decodes the token kind, holds a short queue
// depends on rpn_pkg
`default_nettype none

module rpn_front
  import rpn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         func,
  input  wire logic signed [31:0] value,
  input  wire logic               start_req,
  output logic                    tok_valid,
  output token_t                  tok,
  input  wire logic               tok_pop
);

  token_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  token_t     decoded;
  logic       do_push;

  always_comb begin
    decoded.value = value;
    decoded.start = start_req;
    unique case (func)
      FN_PUSH: decoded.kind = K_PUSH;
      FN_ADD:  decoded.kind = K_ADD;
      FN_SUB:  decoded.kind = K_SUB;
      FN_MUL:  decoded.kind = K_MUL;
      FN_DIV:  decoded.kind = K_DIV;
      default: decoded.kind = K_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign tok_valid = (count != 2'd0);
  assign tok       = slots[rptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (tok_pop) begin
        rptr <= !rptr;
      end
      unique case ({do_push, tok_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_div.sv =====
// signed divider, truncating, one quotient bit per cycle
// depends on rpn_pkg
`default_nettype none

module rpn_div
  import rpn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DATA_W-1:0] b,
  output logic                   done,
  output logic [DATA_W-1:0]      q
);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] mb;
  logic [DATA_W:0]   trial;

  assign trial = {rem, quo[DATA_W-1]} - {1'b0, mb};
  assign q     = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[DATA_W-1] ^ b[DATA_W-1];
      quo <= a[DATA_W-1] ? (DATA_W'(0) - a) : a;
      mb  <= b[DATA_W-1] ? (DATA_W'(0) - b) : b;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
      end
      quo <= {quo[DATA_W-2:0], !trial[DATA_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_back.sv =====
// back end: operand stack, sequencer, result register
// depends on rpn_pkg; the divider sits beside it in the top level
`default_nettype none

module rpn_back
  import rpn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                tok_valid,
  input  wire token_t              tok,
  output logic                     tok_pop,
  output logic                     div_start,
  output logic [DATA_W-1:0]        div_a,
  output logic [DATA_W-1:0]        div_b,
  input  wire logic                div_done,
  input  wire logic [DATA_W-1:0]   div_q,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [31:0]       top_value,
  output logic [DEPTH_W-1:0]       depth,
  output logic [1:0]               error_code
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;

  state_t            state, state_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [1:0]        err, err_next;
  logic [DATA_W-1:0] tos, tos_next;
  logic [DATA_W-1:0] res, res_next;
  token_t            cur, cur_next;

  logic [SP_W-1:0]   sp_eff;
  logic [1:0]        err_eff;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              out_valid;
  logic              out_free;
  logic              out_load;

  assign sp_eff    = tok.start ? '0 : sp;
  assign err_eff   = tok.start ? ERR_NONE : err;
  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;
  assign div_a     = rd_data;
  assign div_b     = tos;

  always_comb begin
    state_next = state;
    sp_next    = sp;
    err_next   = err;
    tos_next   = tos;
    res_next   = res;
    cur_next   = cur;
    tok_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = ADDR_W'(sp_eff - SP_W'(1));
    raddr      = ADDR_W'(sp_eff - SP_W'(2));
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (tok_valid) begin
          tok_pop  = 1'b1;
          cur_next = tok;
          if (tok.start) begin
            sp_next  = '0;
            err_next = ERR_NONE;
          end
          state_next = ST_EMIT;
          if (err_eff == ERR_NONE) begin
            unique case (tok.kind)
              K_PUSH: begin
                if (sp_eff == SP_W'(STACK_DEPTH)) begin
                  err_next = ERR_OVERFLOW;
                end else begin
                  mem_we   = (sp_eff != '0);
                  tos_next = tok.value;
                  sp_next  = sp_eff + SP_W'(1);
                end
              end
              K_ADD, K_SUB, K_MUL, K_DIV: begin
                if (sp_eff < SP_W'(2)) begin
                  err_next = ERR_FEW;
                end else begin
                  mem_re     = 1'b1;
                  state_next = ST_READ;
                end
              end
              default: state_next = ST_EMIT;
            endcase
          end
        end
      end
      ST_READ: begin
        state_next = ST_WB;
        unique case (cur.kind)
          K_ADD: res_next = rd_data + tos;
          K_SUB: res_next = rd_data - tos;
          K_MUL: res_next = rd_data * tos;
          K_DIV: begin
            if (tos == '0) begin
              err_next   = ERR_DIVZERO;
              state_next = ST_EMIT;
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
          default: state_next = ST_EMIT;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          res_next   = div_q;
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        tos_next   = res;
        sp_next    = sp - SP_W'(1);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp    <= '0;
      err   <= ERR_NONE;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    res <= res_next;
    cur <= cur_next;
  end

  // entries below the top of stack; the top lives in tos
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= tos;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_value  <= (sp != '0) ? tos : '0;
      depth      <= DEPTH_W'(sp);
      error_code <= err;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_stack_evaluator.sv =====
// rpn stack evaluator top level: front queue, sequencer and divider
// depends on rpn_pkg, rpn_front, rpn_div, rpn_back and the assertion header
//
// tokens enter through push/full: func selects push number, add, subtract,
// multiply or divide, value is the number for a push, start_req empties the
// stack and clears the error before the token is handled. every token gives
// exactly one result through empty/pop: top_value (0 when the stack is
// empty), depth and error_code. errors are sticky until a start_req token.
// a two-entry token queue in front lets requests arrive while the sequencer
// works. steps per token in the sequencer: push, unknown code, too few
// operands, overflow or any token under an error go straight to emit; add,
// subtract and multiply read the stack, compute, write back and emit; divide
// by zero reads and emits; divide reads, waits for the one-bit-per-cycle
// divider (32 steps), writes back and emits. tokens are handled one at a time:
// the next token is taken only after the last result is loaded.
// the stack top sits in a register, the entries below it in a single-port
// memory of STACK_DEPTH words, read one word per operator token that runs.
// reset (rst, synchronous) empties the stack, clears the error and drops
// queued tokens and any waiting result. when the receiver stalls the result
// is held, the sequencer waits, and full rises once the queue fills.
`default_nettype none
`include "rpn_stack_evaluator_assert.svh"

module rpn_stack_evaluator
  import rpn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         func,
  input  wire logic signed [31:0] value,
  input  wire logic               start_req,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      top_value,
  output logic [6:0]              depth,
  output logic [1:0]              error_code
);

  logic              tok_valid;
  token_t            tok;
  logic              tok_pop;
  logic              div_start;
  logic [DATA_W-1:0] div_a;
  logic [DATA_W-1:0] div_b;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  rpn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .value     (value),
    .start_req (start_req),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  rpn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  rpn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .tok_pop    (tok_pop),
    .div_start  (div_start),
    .div_a      (div_a),
    .div_b      (div_b),
    .div_done   (div_done),
    .div_q      (div_q),
    .empty      (empty),
    .pop        (pop),
    .top_value  (top_value),
    .depth      (depth),
    .error_code (error_code)
  );

  `RPN_ASSERT_NOW(a_pop_valid, tok_pop, tok_valid, "token taken from empty queue")
  `RPN_ASSERT_NOW(a_div_nonzero, div_start, div_b != '0, "divider started with zero divisor")
  `RPN_ASSERT_NEXT(a_div_latency, div_start, !div_done, "divider finished too early")

endmodule

`default_nettype wire

// ===== bench/rpn_stack_evaluator_tb.sv =====
// self-checking bench for rpn_stack_evaluator: directed tokens, then random expressions
// driver and monitor with random gaps; results checked against a behavioral stack model
// depends on rpn_pkg and the rpn_stack_evaluator rtl
`timescale 1ns / 1ps

module rpn_stack_evaluator_tb
  import rpn_pkg::*;
();

  localparam logic [2:0]  FN_LAST     = 3'd7;
  localparam logic [31:0] INT_MIN     = 32'h8000_0000;
  localparam logic [31:0] INT_MAX     = 32'h7fff_ffff;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          TOKEN_GOAL  = 425;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] value;
    logic        start;
    bit          hold;
  } req_t;

  typedef struct {
    logic signed [31:0] top;
    logic [6:0]         depth;
    logic [1:0]         err;
  } res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [2:0]         func = FN_PUSH;
  logic signed [31:0] value = '0;
  logic               start_req = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] top_value;
  logic [6:0]         depth;
  logic [1:0]         error_code;

  req_t req_q[$];
  res_t pending_answers[$];
  req_t drv_req;
  res_t got_ans;

  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_sp = 0;
  logic [1:0]  calc_err = ERR_NONE;

  int send_wait = 0;
  int rx_wait = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int fails = 0;
  int cycle_count = 0;

  rpn_stack_evaluator dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .value      (value),
    .start_req  (start_req),
    .empty      (empty),
    .pop        (pop),
    .top_value  (top_value),
    .depth      (depth),
    .error_code (error_code)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void evaluate_token(logic [2:0] fn, logic [31:0] val, logic st);
    logic [31:0] lhs, rhs, r, ma, mb, q;
    res_t ans;
    if (st) begin
      calc_sp = 0;
      calc_err = ERR_NONE;
    end
    if (calc_err == ERR_NONE) begin
      if (fn == FN_PUSH) begin
        if (calc_sp >= STACK_DEPTH) begin
          calc_err = ERR_OVERFLOW;
        end else begin
          calc_stack[calc_sp] = val;
          calc_sp++;
        end
      end else if (fn <= FN_DIV) begin
        if (calc_sp < 2) begin
          calc_err = ERR_FEW;
        end else begin
          lhs = calc_stack[calc_sp-2];
          rhs = calc_stack[calc_sp-1];
          if (fn == FN_DIV && rhs == '0) begin
            calc_err = ERR_DIVZERO;
          end else begin
            case (fn)
              FN_ADD: r = lhs + rhs;
              FN_SUB: r = lhs - rhs;
              FN_MUL: r = lhs * rhs;
              default: begin
                // truncating divide on magnitudes, sign applied after
                ma = lhs[31] ? -lhs : lhs;
                mb = rhs[31] ? -rhs : rhs;
                q = ma / mb;
                r = (lhs[31] ^ rhs[31]) ? -q : q;
              end
            endcase
            calc_stack[calc_sp-2] = r;
            calc_sp--;
          end
        end
      end
    end
    ans.top = (calc_sp > 0) ? calc_stack[calc_sp-1] : '0;
    ans.depth = 7'(calc_sp);
    ans.err = calc_err;
    pending_answers = {pending_answers, ans};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'hffff_ffff;
      2: return INT_MIN;
      3: return INT_MAX;
      4, 5: return 32'($urandom_range(0, 80)) - 32'd40;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [2:0] fn, logic [31:0] val, logic st, bit hold);
    req_t t;
    t.func = fn;
    t.value = val;
    t.start = st;
    t.hold = hold;
    req_q = {req_q, t};
  endtask

  task automatic fill_stack(bit overflow);
    add_req(FN_PUSH, pick_value(), 1'b1, 1'b0);
    for (int i = 1; i < STACK_DEPTH; i++) add_req(FN_PUSH, pick_value(), 1'b0, 1'b0);
    if (overflow) begin
      add_req(FN_PUSH, pick_value(), 1'b0, 1'b0);
      add_req(FN_ADD, $urandom, 1'b0, 1'b0);
    end else begin
      repeat (4) add_req(3'($urandom_range(FN_ADD, FN_DIV)), $urandom, 1'b0, 1'b0);
    end
  endtask

  task automatic build_expression();
    int len, level, r;
    len = $urandom_range(3, 30);
    level = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0 && r < 8) begin
        // noise: any code, occasional restart
        add_req(3'($urandom_range(FN_PUSH, FN_LAST)), $urandom,
                $urandom_range(0, 9) == 0, 1'b0);
      end else if (level < 2 || (r < 55 && level < STACK_DEPTH - 2)) begin
        add_req(FN_PUSH, pick_value(), i == 0, i == 0 && $urandom_range(0, 49) == 0);
        level++;
      end else begin
        add_req(3'($urandom_range(FN_ADD, FN_DIV)), $urandom, 1'b0, 1'b0);
        level--;
      end
    end
  endtask

  // request side
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_wait = 0;
    end else begin
      if (push && !full) begin
        evaluate_token(func, value, start_req);
        if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
        send_wait = tx_calm ? 0 : pick_gap();
      end
      if (!push || !full) begin
        if (send_wait > 0) begin
          push <= 1'b0;
          send_wait--;
        end else if (req_q.size() > 0 && !(req_q[0].hold && pending_answers.size() > 0)) begin
          drv_req = req_q.pop_front();
          func <= drv_req.func;
          value <= drv_req.value;
          start_req <= drv_req.start;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_answers.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          got_ans = pending_answers.pop_front();
          if (top_value !== got_ans.top) begin
            $error("top_value: expected %0d, got %0d", got_ans.top, top_value);
            fails++;
          end
          if (depth !== got_ans.depth) begin
            $error("depth: expected %0d, got %0d", got_ans.depth, depth);
            fails++;
          end
          if (error_code !== got_ans.err) begin
            $error("error_code: expected %0d, got %0d", got_ans.err, error_code);
            fails++;
          end
        end
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : pick_gap();
      end
      if (rx_wait > 0) begin
        pop <= 1'b0;
        rx_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // wraparound, min over minus one, multiply, subtract and an unknown code
    add_req(FN_PUSH, INT_MAX, 1'b1, 1'b0);
    add_req(FN_PUSH, 32'd1, 1'b0, 1'b0);
    add_req(FN_ADD, INT_MAX, 1'b0, 1'b0);
    add_req(FN_PUSH, 32'hffff_ffff, 1'b0, 1'b0);
    add_req(FN_DIV, '0, 1'b0, 1'b0);
    add_req(FN_PUSH, 32'd3, 1'b0, 1'b0);
    add_req(FN_MUL, 32'hffff_ffff, 1'b0, 1'b0);
    add_req(FN_PUSH, '0, 1'b0, 1'b0);
    add_req(FN_SUB, INT_MIN, 1'b0, 1'b0);
    add_req(FN_DIV + 3'd1, 32'hffff_ffff, 1'b0, 1'b0);
    // divide by zero, then sticky error
    add_req(FN_PUSH, '0, 1'b0, 1'b0);
    add_req(FN_DIV, '0, 1'b0, 1'b0);
    add_req(FN_PUSH, 32'd5, 1'b0, 1'b1);
    add_req(FN_ADD, '0, 1'b0, 1'b0);
    // truncation toward zero
    add_req(FN_PUSH, 32'hffff_fff9, 1'b1, 1'b0);
    add_req(FN_PUSH, 32'd2, 1'b0, 1'b0);
    add_req(FN_DIV, '0, 1'b0, 1'b0);
    // too few operands, restarts and unknown codes
    add_req(FN_SUB, '0, 1'b0, 1'b0);
    add_req(FN_LAST, INT_MIN, 1'b1, 1'b0);
    add_req(FN_ADD, '0, 1'b1, 1'b0);
    add_req(FN_PUSH, '0, 1'b1, 1'b0);
    add_req(FN_PUSH, INT_MIN, 1'b0, 1'b0);
    add_req(FN_MUL, '0, 1'b0, 1'b0);
    add_req(FN_DIV + 3'd2, $urandom, 1'b0, 1'b0);
    // full stack with and without overflow
    fill_stack(1'b1);
    fill_stack(1'b0);
    while (req_q.size() < TOKEN_GOAL) begin
      if ($urandom_range(0, 24) == 0) fill_stack($urandom_range(0, 1));
      else build_expression();
    end

    do @(negedge clk); while (req_q.size() > 0 || push || pending_answers.size() > 0);
    repeat (80) @(posedge clk);
    if (fails == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
